// ----- hdl/symmetry_copy_euler_offset_top_defines.svh -----
// Assertion macros shared by the symmetry copy Euler offset RTL.
`ifndef SYMMETRY_COPY_EULER_OFFSET_TOP_DEFINES_SVH
`define SYMMETRY_COPY_EULER_OFFSET_TOP_DEFINES_SVH

// Same-cycle implication, checked only while out of reset.
`define SCOE_ASSERT_IMPLY(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Implication that fires a fixed number of cycles after the antecedent.
`define SCOE_ASSERT_LATER(label, ck, rn, ante, dly, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> ##(dly) (cons)) \
        else $error(msg);

`endif

// ----- hdl/scoe_pkg.sv -----
// Shared constants, types and tables of the symmetry copy Euler offset block.
`timescale 1ns / 1ps
package scoe_pkg;

    localparam int FRAC_BITS       = 8;
    localparam int MAX_ORDER       = 32;
    localparam int ANG_Q           = 16;
    localparam int TRIG_SHIFT      = 30;
    localparam int CORDIC_STEPS    = 16;
    localparam int CORDIC_STAGES   = 4;
    localparam int STEPS_PER_STAGE = CORDIC_STEPS / CORDIC_STAGES;
    localparam int CORDIC_GAIN     = 652032874;

    localparam int FULL_Q8    = 360 * (2 ** FRAC_BITS);
    localparam int HALF_Q8    = 180 * (2 ** FRAC_BITS);
    localparam int QUARTER_Q8 = 90 * (2 ** FRAC_BITS);

    localparam int K_W      = 6;
    localparam int ANG_W    = 19;
    localparam int ROT_W    = 20;
    localparam int OFS_W    = 19;
    localparam int SHIFT_W  = 20;
    localparam int CFG_W    = 19;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_W    = 22;
    localparam int RECIP_W  = 28;
    localparam int RECIP_SHIFT = 27;
    localparam int OFF_W    = 17;
    localparam int RED_W    = 18;
    localparam int LIFT_W   = 22;
    localparam int Z_W      = 26;
    localparam int XY_W     = 33;
    localparam int TRIG_W   = 32;
    localparam int ROW_W    = 33;
    localparam int PROD_W   = ROW_W + OFS_W;
    localparam int ACC_W    = PROD_W + 2;

    // Sideband delay from the angle stage to the last matrix stage.
    localparam int SB_DEPTH = 9;
    // Cycles from the accepting edge to the edge that takes the result.
    localparam int PIPE_LAT = 14;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GROUP_KIND     = 3'd0,
        REG_SYMMETRY_ORDER = 3'd1,
        REG_OFFSET_X       = 3'd2,
        REG_OFFSET_Y       = 3'd3,
        REG_OFFSET_Z       = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic signed [TRIG_W-1:0] cz0;
        logic signed [TRIG_W-1:0] sz0;
        logic signed [TRIG_W-1:0] cy;
        logic signed [TRIG_W-1:0] sy;
        logic signed [TRIG_W-1:0] cz1;
        logic signed [TRIG_W-1:0] sz1;
    } trig_set_t;

    // ceil(2^27 / n); exact floor division of numerators below 2^22.
    function automatic logic [RECIP_W-1:0] recip_of(input logic [K_W-1:0] n);
        logic [RECIP_W-1:0] r;
        case (n)
            6'd1:    r = 28'd134217728;
            6'd2:    r = 28'd67108864;
            6'd3:    r = 28'd44739243;
            6'd4:    r = 28'd33554432;
            6'd5:    r = 28'd26843546;
            6'd6:    r = 28'd22369622;
            6'd7:    r = 28'd19173962;
            6'd8:    r = 28'd16777216;
            6'd9:    r = 28'd14913081;
            6'd10:   r = 28'd13421773;
            6'd11:   r = 28'd12201612;
            6'd12:   r = 28'd11184811;
            6'd13:   r = 28'd10324441;
            6'd14:   r = 28'd9586981;
            6'd15:   r = 28'd8947849;
            6'd16:   r = 28'd8388608;
            6'd17:   r = 28'd7895161;
            6'd18:   r = 28'd7456541;
            6'd19:   r = 28'd7064091;
            6'd20:   r = 28'd6710887;
            6'd21:   r = 28'd6391321;
            6'd22:   r = 28'd6100806;
            6'd23:   r = 28'd5835554;
            6'd24:   r = 28'd5592406;
            6'd25:   r = 28'd5368710;
            6'd26:   r = 28'd5162221;
            6'd27:   r = 28'd4971027;
            6'd28:   r = 28'd4793491;
            6'd29:   r = 28'd4628198;
            6'd30:   r = 28'd4473925;
            6'd31:   r = 28'd4329605;
            6'd32:   r = 28'd4194304;
            default: r = '0;
        endcase
        return r;
    endfunction

    // atan(2^-i) in degrees, Q16.
    function automatic logic signed [Z_W-1:0] atan_of(input int i);
        logic signed [Z_W-1:0] a;
        case (i)
            0:       a = 26'sd2949120;
            1:       a = 26'sd1740967;
            2:       a = 26'sd919879;
            3:       a = 26'sd466945;
            4:       a = 26'sd234379;
            5:       a = 26'sd117304;
            6:       a = 26'sd58666;
            7:       a = 26'sd29335;
            8:       a = 26'sd14668;
            9:       a = 26'sd7334;
            10:      a = 26'sd3667;
            11:      a = 26'sd1833;
            12:      a = 26'sd917;
            13:      a = 26'sd458;
            14:      a = 26'sd229;
            15:      a = 26'sd115;
            default: a = '0;
        endcase
        return a;
    endfunction

    // Q30 product with a floor shift back to Q30.
    function automatic logic signed [TRIG_W-1:0] mq(input logic signed [TRIG_W-1:0] a,
                                                    input logic signed [TRIG_W-1:0] b);
        logic signed [2*TRIG_W-1:0] p;
        p = (2*TRIG_W)'(a) * (2*TRIG_W)'(b);
        return p[TRIG_SHIFT+TRIG_W-1:TRIG_SHIFT];
    endfunction

endpackage

// ----- hdl/scoe_cordic.sv -----
// Angle reduction and pipelined rotation CORDIC giving cosine and sine in Q30.
`timescale 1ns / 1ps
module scoe_cordic (
    input  logic                                   clk,
    input  logic signed [scoe_pkg::ROT_W-1:0]      angle,
    output logic signed [scoe_pkg::TRIG_W-1:0]     cos_val,
    output logic signed [scoe_pkg::TRIG_W-1:0]     sin_val
);
    import scoe_pkg::*;

    logic signed [Z_W-1:0]  z_first_next;
    logic                   neg_first_next;
    logic signed [Z_W-1:0]  z_first_reg;
    logic                   neg_reg [0:CORDIC_STAGES];
    logic signed [XY_W-1:0] x_reg [1:CORDIC_STAGES];
    logic signed [XY_W-1:0] y_reg [1:CORDIC_STAGES];
    logic signed [Z_W-1:0]  z_reg [1:CORDIC_STAGES];
    logic signed [TRIG_W-1:0] cos_reg;
    logic signed [TRIG_W-1:0] sin_reg;

    // Reduce to [0, 360), then to (-180, 180], then fold into +-90.
    always_comb
    begin
        logic signed [LIFT_W-1:0] lifted;
        logic signed [LIFT_W-1:0] wrapped;
        logic signed [RED_W-1:0]  centered;
        logic signed [RED_W-1:0]  folded;
        lifted = LIFT_W'(angle) + LIFT_W'(4 * FULL_Q8);
        if (lifted >= LIFT_W'(6 * FULL_Q8))
        begin
            wrapped = lifted - LIFT_W'(6 * FULL_Q8);
        end
        else if (lifted >= LIFT_W'(5 * FULL_Q8))
        begin
            wrapped = lifted - LIFT_W'(5 * FULL_Q8);
        end
        else if (lifted >= LIFT_W'(4 * FULL_Q8))
        begin
            wrapped = lifted - LIFT_W'(4 * FULL_Q8);
        end
        else if (lifted >= LIFT_W'(3 * FULL_Q8))
        begin
            wrapped = lifted - LIFT_W'(3 * FULL_Q8);
        end
        else if (lifted >= LIFT_W'(2 * FULL_Q8))
        begin
            wrapped = lifted - LIFT_W'(2 * FULL_Q8);
        end
        else if (lifted >= LIFT_W'(FULL_Q8))
        begin
            wrapped = lifted - LIFT_W'(FULL_Q8);
        end
        else
        begin
            wrapped = lifted;
        end
        if (wrapped > LIFT_W'(HALF_Q8))
        begin
            centered = RED_W'(wrapped - LIFT_W'(FULL_Q8));
        end
        else
        begin
            centered = RED_W'(wrapped);
        end
        neg_first_next = 1'b0;
        folded = centered;
        if (centered > RED_W'(QUARTER_Q8))
        begin
            folded = centered - RED_W'(HALF_Q8);
            neg_first_next = 1'b1;
        end
        else if (centered < -RED_W'(QUARTER_Q8))
        begin
            folded = centered + RED_W'(HALF_Q8);
            neg_first_next = 1'b1;
        end
        z_first_next = Z_W'(folded) <<< (ANG_Q - FRAC_BITS);
    end

    always_ff @(posedge clk)
    begin
        z_first_reg <= z_first_next;
        neg_reg[0]  <= neg_first_next;
    end

    for (genvar s = 0; s < CORDIC_STAGES; s++)
    begin : g_stage
        logic signed [XY_W-1:0] x_in;
        logic signed [XY_W-1:0] y_in;
        logic signed [Z_W-1:0]  z_in;
        logic signed [XY_W-1:0] x_next;
        logic signed [XY_W-1:0] y_next;
        logic signed [Z_W-1:0]  z_next;

        if (s == 0)
        begin : g_head
            assign x_in = XY_W'(CORDIC_GAIN);
            assign y_in = '0;
            assign z_in = z_first_reg;
        end
        else
        begin : g_body
            assign x_in = x_reg[s];
            assign y_in = y_reg[s];
            assign z_in = z_reg[s];
        end

        always_comb
        begin
            logic signed [XY_W-1:0] xt;
            logic signed [XY_W-1:0] yt;
            logic signed [XY_W-1:0] dx;
            logic signed [XY_W-1:0] dy;
            logic signed [Z_W-1:0]  zt;
            xt = x_in;
            yt = y_in;
            zt = z_in;
            for (int j = 0; j < STEPS_PER_STAGE; j++)
            begin
                dx = yt >>> (s * STEPS_PER_STAGE + j);
                dy = xt >>> (s * STEPS_PER_STAGE + j);
                if (zt >= 0)
                begin
                    xt = xt - dx;
                    yt = yt + dy;
                    zt = zt - atan_of(s * STEPS_PER_STAGE + j);
                end
                else
                begin
                    xt = xt + dx;
                    yt = yt - dy;
                    zt = zt + atan_of(s * STEPS_PER_STAGE + j);
                end
            end
            x_next = xt;
            y_next = yt;
            z_next = zt;
        end

        always_ff @(posedge clk)
        begin
            x_reg[s+1]   <= x_next;
            y_reg[s+1]   <= y_next;
            z_reg[s+1]   <= z_next;
            neg_reg[s+1] <= neg_reg[s];
        end
    end

    always_ff @(posedge clk)
    begin
        if (neg_reg[CORDIC_STAGES])
        begin
            cos_reg <= TRIG_W'(-x_reg[CORDIC_STAGES]);
            sin_reg <= TRIG_W'(-y_reg[CORDIC_STAGES]);
        end
        else
        begin
            cos_reg <= TRIG_W'(x_reg[CORDIC_STAGES]);
            sin_reg <= TRIG_W'(y_reg[CORDIC_STAGES]);
        end
    end

    assign cos_val = cos_reg;
    assign sin_val = sin_reg;

endmodule

// ----- hdl/scoe_matrix.sv -----
// Rotation matrix rows and projection of the 3D offset onto a 2D shift.
`timescale 1ns / 1ps
module scoe_matrix (
    input  logic                                 clk,
    input  scoe_pkg::trig_set_t                  trig,
    input  logic signed [scoe_pkg::OFS_W-1:0]    offset_x,
    input  logic signed [scoe_pkg::OFS_W-1:0]    offset_y,
    input  logic signed [scoe_pkg::OFS_W-1:0]    offset_z,
    output logic signed [scoe_pkg::SHIFT_W-1:0]  shift_x,
    output logic signed [scoe_pkg::SHIFT_W-1:0]  shift_y
);
    import scoe_pkg::*;

    // First products.
    logic signed [TRIG_W-1:0] cyz0_reg, s0s1_reg, c1s0_reg, rx2_reg, cyc1_reg;
    logic signed [TRIG_W-1:0] c0s1_reg, c0c1_reg, cys0_reg, ry2_reg;
    logic signed [TRIG_W-1:0] cz1_reg, sz1_reg, sz0_reg;
    // Second products and carried terms.
    logic signed [TRIG_W-1:0] q1_reg, q2_reg, q3_reg, q4_reg;
    logic signed [TRIG_W-1:0] s0s1_p2_reg, c1s0_p2_reg, rx2_p2_reg;
    logic signed [TRIG_W-1:0] c0s1_p2_reg, c0c1_p2_reg, ry2_p2_reg;
    // Row entries times offsets.
    logic signed [PROD_W-1:0] px0_reg, px1_reg, px2_reg, py0_reg, py1_reg, py2_reg;
    logic signed [ROW_W-1:0]  rx0_next, rx1_next, ry0_next, ry1_next;

    always_ff @(posedge clk)
    begin
        cyz0_reg <= mq(trig.cy, trig.cz0);
        s0s1_reg <= mq(trig.sz0, trig.sz1);
        c1s0_reg <= mq(trig.cz1, trig.sz0);
        rx2_reg  <= mq(trig.sy, trig.cz0);
        cyc1_reg <= mq(trig.cy, trig.cz1);
        c0s1_reg <= mq(trig.cz0, trig.sz1);
        c0c1_reg <= mq(trig.cz0, trig.cz1);
        cys0_reg <= mq(trig.cy, trig.sz0);
        ry2_reg  <= mq(trig.sy, trig.sz0);
        cz1_reg  <= trig.cz1;
        sz1_reg  <= trig.sz1;
        sz0_reg  <= trig.sz0;
    end

    always_ff @(posedge clk)
    begin
        q1_reg      <= mq(cyz0_reg, cz1_reg);
        q2_reg      <= mq(cyz0_reg, sz1_reg);
        q3_reg      <= mq(cyc1_reg, sz0_reg);
        q4_reg      <= mq(cys0_reg, sz1_reg);
        s0s1_p2_reg <= s0s1_reg;
        c1s0_p2_reg <= c1s0_reg;
        rx2_p2_reg  <= rx2_reg;
        c0s1_p2_reg <= c0s1_reg;
        c0c1_p2_reg <= c0c1_reg;
        ry2_p2_reg  <= ry2_reg;
    end

    assign rx0_next = ROW_W'(q1_reg) - ROW_W'(s0s1_p2_reg);
    assign rx1_next = -ROW_W'(c1s0_p2_reg) - ROW_W'(q2_reg);
    assign ry0_next = ROW_W'(q3_reg) + ROW_W'(c0s1_p2_reg);
    assign ry1_next = ROW_W'(c0c1_p2_reg) - ROW_W'(q4_reg);

    always_ff @(posedge clk)
    begin
        px0_reg <= PROD_W'(rx0_next) * PROD_W'(offset_x);
        px1_reg <= PROD_W'(rx1_next) * PROD_W'(offset_y);
        px2_reg <= PROD_W'(rx2_p2_reg) * PROD_W'(offset_z);
        py0_reg <= PROD_W'(ry0_next) * PROD_W'(offset_x);
        py1_reg <= PROD_W'(ry1_next) * PROD_W'(offset_y);
        py2_reg <= PROD_W'(ry2_p2_reg) * PROD_W'(offset_z);
    end

    // Round half up out of Q30 and saturate to the shift width.
    function automatic logic signed [SHIFT_W-1:0] round_sat(
        input logic signed [PROD_W-1:0] a,
        input logic signed [PROD_W-1:0] b,
        input logic signed [PROD_W-1:0] c);
        logic signed [ACC_W-1:0] acc;
        logic signed [ACC_W-1:0] scaled;
        logic signed [SHIFT_W-1:0] r;
        acc = ACC_W'(a) + ACC_W'(b) + ACC_W'(c) + (ACC_W'(1) <<< (TRIG_SHIFT - 1));
        scaled = acc >>> TRIG_SHIFT;
        if (scaled > ACC_W'((2 ** (SHIFT_W - 1)) - 1))
        begin
            r = SHIFT_W'((2 ** (SHIFT_W - 1)) - 1);
        end
        else if (scaled < -ACC_W'(2 ** (SHIFT_W - 1)))
        begin
            r = SHIFT_W'(-(2 ** (SHIFT_W - 1)));
        end
        else
        begin
            r = SHIFT_W'(scaled);
        end
        return r;
    endfunction

    assign shift_x = round_sat(px0_reg, px1_reg, px2_reg);
    assign shift_y = round_sat(py0_reg, py1_reg, py2_reg);

endmodule

// ----- hdl/symmetry_copy_euler_offset_top.sv -----
// Top level of the symmetry copy Euler offset block: copy angles and projected shift.
// A beat accepted at a clock edge passes stages 0 to 3, the CORDIC and matrix stages
// beside the sideband line; the output register shows its result with done high.
// Throughput is one beat per clock, set by the fully pipelined CORDIC and multipliers.
// busy is always low since the receiver cannot stall the pipeline.
// Reset (rst_n low, asynchronous) clears every valid bit and sets the registers
// to cyclic, order one and zero offset; no clearing pass is needed.
`timescale 1ns / 1ps
`include "symmetry_copy_euler_offset_top_defines.svh"
module symmetry_copy_euler_offset_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  cfg_write,
    input  logic [scoe_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [scoe_pkg::CFG_W-1:0]            cfg_data,
    input  logic [scoe_pkg::K_W-1:0]              copy_index,
    input  logic signed [scoe_pkg::ANG_W-1:0]     rot_in,
    input  logic signed [scoe_pkg::ANG_W-1:0]     tilt_in,
    input  logic signed [scoe_pkg::ANG_W-1:0]     psi_in,
    output logic                                  done,
    output logic                                  index_valid,
    output logic signed [scoe_pkg::ROT_W-1:0]     rot_out,
    output logic signed [scoe_pkg::ANG_W-1:0]     tilt_out,
    output logic signed [scoe_pkg::ANG_W-1:0]     psi_out,
    output logic signed [scoe_pkg::SHIFT_W-1:0]   shift_x,
    output logic signed [scoe_pkg::SHIFT_W-1:0]   shift_y
);
    import scoe_pkg::*;

    // Sideband that rides alongside the trigonometry and matrix stages.
    typedef struct packed {
        logic                    ok;
        logic signed [ROT_W-1:0] rot_a;
        logic signed [ANG_W-1:0] tilt;
        logic signed [ROT_W-1:0] psi_a;
    } sideband_t;

    // Configuration registers. Change them only while the pipeline is empty; the block does not check this.
    logic                    group_kind_reg;
    logic [K_W-1:0]          order_reg;
    logic signed [OFS_W-1:0] offset_x_reg;
    logic signed [OFS_W-1:0] offset_y_reg;
    logic signed [OFS_W-1:0] offset_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_kind_reg <= 1'b0;
            order_reg      <= K_W'(1);
            offset_x_reg   <= '0;
            offset_y_reg   <= '0;
            offset_z_reg   <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_GROUP_KIND:     group_kind_reg <= cfg_data[0];
                REG_SYMMETRY_ORDER: order_reg      <= cfg_data[K_W-1:0];
                REG_OFFSET_X:       offset_x_reg   <= $signed(cfg_data[OFS_W-1:0]);
                REG_OFFSET_Y:       offset_y_reg   <= $signed(cfg_data[OFS_W-1:0]);
                REG_OFFSET_Z:       offset_z_reg   <= $signed(cfg_data[OFS_W-1:0]);
                default:            ;
            endcase
        end
    end

    // Nothing downstream can hold off a result, so the pipeline never stalls.
    assign busy = 1'b0;

    // Stage 0: capture the input beat.
    logic                    v0_reg;
    logic [K_W-1:0]          k0_reg;
    logic signed [ANG_W-1:0] rot0_reg, tilt0_reg, psi0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        k0_reg    <= copy_index;
        rot0_reg  <= rot_in;
        tilt0_reg <= tilt_in;
        psi0_reg  <= psi_in;
    end

    // Stage 1: decode the copy index. The copy's rot offset is
    // round(360 * c / N), formed as floor((360 * 2^8 * c + N / 2) / N), and the
    // division by N is done by an exact reciprocal multiply in stage 2.
    // The adjusted psi is kept one bit wider so the trigonometry sees it unclamped.
    logic [K_W-1:0]          order_n;
    logic [K_W:0]            copy_count;
    logic                    second_half;
    logic [K_W-1:0]          c_idx;
    logic                    ok1_next;
    logic [NUM_W-1:0]        num1_next;
    logic [RECIP_W-1:0]      recip1_next;
    logic signed [ROT_W-1:0] psi_a1_next;

    always_comb
    begin
        order_n     = (order_reg > K_W'(MAX_ORDER)) ? K_W'(MAX_ORDER) : order_reg;
        copy_count  = group_kind_reg ? {order_n, 1'b0} : {1'b0, order_n};
        ok1_next    = {1'b0, k0_reg} < copy_count;
        second_half = group_kind_reg && (k0_reg >= order_n);
        c_idx       = second_half ? (k0_reg - order_n) : k0_reg;
        num1_next   = NUM_W'(c_idx) * NUM_W'(FULL_Q8) + NUM_W'(order_n >> 1);
        recip1_next = recip_of(order_n);
        psi_a1_next = second_half ? (ROT_W'(psi0_reg) + ROT_W'(HALF_Q8)) : ROT_W'(psi0_reg);
    end

    logic                    v1_reg, ok1_reg;
    logic [NUM_W-1:0]        num1_reg;
    logic [RECIP_W-1:0]      recip1_reg;
    logic signed [ANG_W-1:0] rot1_reg, tilt1_reg;
    logic signed [ROT_W-1:0] psi_a1_reg;

    // Stage 2: reciprocal multiply gives the rot offset.
    logic [NUM_W+RECIP_W-1:0] quot_prod;
    logic [OFF_W-1:0]         off2_next;
    logic                     v2_reg, ok2_reg;
    logic [OFF_W-1:0]         off2_reg;
    logic signed [ANG_W-1:0]  rot2_reg, tilt2_reg;
    logic signed [ROT_W-1:0]  psi_a2_reg;

    assign quot_prod = (NUM_W + RECIP_W)'(num1_reg) * (NUM_W + RECIP_W)'(recip1_reg);
    assign off2_next = quot_prod[RECIP_SHIFT+OFF_W-1:RECIP_SHIFT];

    // Stage 3: adjusted rot angle.
    logic signed [ROT_W-1:0] rot_a3_next;
    logic                    v3_reg, ok3_reg;
    logic signed [ROT_W-1:0] rot_a3_reg;
    logic signed [ANG_W-1:0] tilt3_reg;
    logic signed [ROT_W-1:0] psi_a3_reg;

    assign rot_a3_next = ROT_W'(rot2_reg) + $signed(ROT_W'(off2_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ok1_reg    <= ok1_next;
        num1_reg   <= num1_next;
        recip1_reg <= recip1_next;
        rot1_reg   <= rot0_reg;
        tilt1_reg  <= tilt0_reg;
        psi_a1_reg <= psi_a1_next;

        ok2_reg    <= ok1_reg;
        off2_reg   <= off2_next;
        rot2_reg   <= rot1_reg;
        tilt2_reg  <= tilt1_reg;
        psi_a2_reg <= psi_a1_reg;

        ok3_reg    <= ok2_reg;
        rot_a3_reg <= rot_a3_next;
        tilt3_reg  <= tilt2_reg;
        psi_a3_reg <= psi_a2_reg;
    end

    // The matrix is built from the negated angles (-psi, -tilt, -rot).
    logic signed [ROT_W-1:0] neg_psi, neg_tilt, neg_rot;
    trig_set_t               trig;

    assign neg_psi  = -psi_a3_reg;
    assign neg_tilt = -ROT_W'(tilt3_reg);
    assign neg_rot  = -rot_a3_reg;

    scoe_cordic u_cordic_psi (
        .clk     (clk),
        .angle   (neg_psi),
        .cos_val (trig.cz0),
        .sin_val (trig.sz0)
    );

    scoe_cordic u_cordic_tilt (
        .clk     (clk),
        .angle   (neg_tilt),
        .cos_val (trig.cy),
        .sin_val (trig.sy)
    );

    scoe_cordic u_cordic_rot (
        .clk     (clk),
        .angle   (neg_rot),
        .cos_val (trig.cz1),
        .sin_val (trig.sz1)
    );

    logic signed [SHIFT_W-1:0] mat_shift_x, mat_shift_y;

    scoe_matrix u_matrix (
        .clk      (clk),
        .trig     (trig),
        .offset_x (offset_x_reg),
        .offset_y (offset_y_reg),
        .offset_z (offset_z_reg),
        .shift_x  (mat_shift_x),
        .shift_y  (mat_shift_y)
    );

    // Sideband delay line, matched to the six CORDIC and three matrix registers.
    sideband_t sb_reg [0:SB_DEPTH-1];
    logic      sb_v_reg [0:SB_DEPTH-1];
    sideband_t sb_head;

    assign sb_head = '{ok: ok3_reg, rot_a: rot_a3_reg, tilt: tilt3_reg, psi_a: psi_a3_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SB_DEPTH; i++)
            begin
                sb_v_reg[i] <= 1'b0;
            end
        end
        else
        begin
            sb_v_reg[0] <= v3_reg;
            for (int i = 1; i < SB_DEPTH; i++)
            begin
                sb_v_reg[i] <= sb_v_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sb_reg[0] <= sb_head;
        for (int i = 1; i < SB_DEPTH; i++)
        begin
            sb_reg[i] <= sb_reg[i-1];
        end
    end

    // The adjusted psi can pass the top of its output field in the dihedral
    // second half, so it is clamped there. The adjusted rot always fits.
    logic signed [ANG_W-1:0] psi_sat;

    always_comb
    begin
        if (sb_reg[SB_DEPTH-1].psi_a > ROT_W'((2 ** (ANG_W - 1)) - 1))
        begin
            psi_sat = ANG_W'((2 ** (ANG_W - 1)) - 1);
        end
        else if (sb_reg[SB_DEPTH-1].psi_a < -ROT_W'(2 ** (ANG_W - 1)))
        begin
            psi_sat = ANG_W'(-(2 ** (ANG_W - 1)));
        end
        else
        begin
            psi_sat = ANG_W'(sb_reg[SB_DEPTH-1].psi_a);
        end
    end

    // Output register. An out-of-range copy index zeroes every field.
    logic                      done_reg;
    logic                      index_valid_reg;
    logic signed [ROT_W-1:0]   rot_out_reg;
    logic signed [ANG_W-1:0]   tilt_out_reg, psi_out_reg;
    logic signed [SHIFT_W-1:0] shift_x_reg, shift_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= sb_v_reg[SB_DEPTH-1];
        end
    end

    always_ff @(posedge clk)
    begin
        index_valid_reg <= sb_reg[SB_DEPTH-1].ok;
        if (sb_reg[SB_DEPTH-1].ok)
        begin
            rot_out_reg  <= sb_reg[SB_DEPTH-1].rot_a;
            tilt_out_reg <= sb_reg[SB_DEPTH-1].tilt;
            psi_out_reg  <= psi_sat;
            shift_x_reg  <= mat_shift_x;
            shift_y_reg  <= mat_shift_y;
        end
        else
        begin
            rot_out_reg  <= '0;
            tilt_out_reg <= '0;
            psi_out_reg  <= '0;
            shift_x_reg  <= '0;
            shift_y_reg  <= '0;
        end
    end

    assign done        = done_reg;
    assign index_valid = index_valid_reg;
    assign rot_out     = rot_out_reg;
    assign tilt_out    = tilt_out_reg;
    assign psi_out     = psi_out_reg;
    assign shift_x     = shift_x_reg;
    assign shift_y     = shift_y_reg;

    // Every accepted beat comes out exactly once, a fixed number of cycles later.
    `SCOE_ASSERT_LATER(a_beat_out, clk, rst_n, start && !busy, PIPE_LAT, done, "accepted beat did not complete")
    `SCOE_ASSERT_IMPLY(a_no_phantom, clk, rst_n, done, $past(start, PIPE_LAT), "result beat without an input beat")
    // The reciprocal multiply must keep a valid copy's offset below a full turn.
    `SCOE_ASSERT_IMPLY(a_off_range, clk, rst_n, v2_reg && ok2_reg, off2_reg < OFF_W'(FULL_Q8), "rot offset out of range")
    `SCOE_ASSERT_IMPLY(a_invalid_zero, clk, rst_n, done && !index_valid, (rot_out == 0) && (psi_out == 0) && (shift_x == 0) && (shift_y == 0), "invalid copy result not zero")

endmodule

// ----- tb/tb_symmetry_copy_euler_offset_top.sv -----
// Self-checking testbench of the symmetry copy Euler offset block.
`timescale 1ns / 1ps
module tb_symmetry_copy_euler_offset_top;
    import scoe_pkg::*;

    // CORDIC step angles, atan(2^-i) in degrees with 16 fraction bits.
    localparam longint STEP_ANGLE [16] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115
    };
    localparam longint GAIN_Q30 = 652032874;

    // One expected result beat, held as plain integers.
    typedef struct {
        bit     valid;
        longint rot;
        longint tilt;
        longint psi;
        longint sx;
        longint sy;
    } copy_result_t;

    // Predicts the copy angles and shift of every accepted beat and checks the
    // result beats against them in order.
    class euler_scoreboard;
        bit           dihedral;
        longint       order_reg;
        longint       ofs_x, ofs_y, ofs_z;
        copy_result_t pending[$];
        int           errors;
        int           beats_in;
        int           beats_out;
        int           valid_seen;

        function new();
            dihedral  = 1'b0;
            order_reg = 1;
            ofs_x = 0;
            ofs_y = 0;
            ofs_z = 0;
            errors = 0;
            beats_in = 0;
            beats_out = 0;
            valid_seen = 0;
        endfunction

        function longint clamp(longint v, int w);
            longint hi;
            longint lo;
            hi = (longint'(1) <<< (w - 1)) - 1;
            lo = -hi - 1;
            return (v > hi) ? hi : ((v < lo) ? lo : v);
        endfunction

        function longint qmul(longint a, longint b);
            return (a * b) >>> 30;
        endfunction

        // Cosine and sine in Q30 of an angle in degrees with 8 fraction bits.
        function void cos_sin(longint a, output longint c, output longint s);
            longint full;
            longint half;
            longint quarter;
            longint r;
            longint x;
            longint y;
            longint z;
            longint dx;
            longint dy;
            bit     flip;
            full    = 360 * 256;
            half    = longint'(180) <<< 16;
            quarter = longint'(90) <<< 16;
            flip    = 1'b0;
            r = a % full;
            if (r < 0)
                r += full;
            r = r * 256;
            if (r > half)
                r -= 2 * half;
            if (r > quarter)
            begin
                r -= half;
                flip = 1'b1;
            end
            else if (r < -quarter)
            begin
                r += half;
                flip = 1'b1;
            end
            x = GAIN_Q30;
            y = 0;
            z = r;
            for (int i = 0; i < 16; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0)
                begin
                    x -= dx;
                    y += dy;
                    z -= STEP_ANGLE[i];
                end
                else
                begin
                    x += dx;
                    y -= dy;
                    z += STEP_ANGLE[i];
                end
            end
            c = flip ? -x : x;
            s = flip ? -y : y;
        endfunction

        function longint project_row(longint r0, longint r1, longint r2);
            longint acc;
            acc = r0 * ofs_x + r1 * ofs_y + r2 * ofs_z;
            acc = (acc + (longint'(1) <<< 29)) >>> 30;
            return clamp(acc, 20);
        endfunction

        function copy_result_t predict_copy(longint k, longint rot, longint tilt, longint psi);
            copy_result_t res;
            longint n;
            longint copies;
            longint half_sel;
            longint c;
            longint rot_a;
            longint psi_a;
            longint cz0, sz0, cy, sy, cz1, sz1, cyz0;
            n = (order_reg > MAX_ORDER) ? MAX_ORDER : order_reg;
            copies = dihedral ? 2 * n : n;
            res = '{valid: 1'b0, rot: 0, tilt: 0, psi: 0, sx: 0, sy: 0};
            if (k >= copies)
                return res;
            half_sel = (dihedral && k >= n) ? 1 : 0;
            c = k - n * half_sel;
            rot_a = rot + ((360 * 256) * c + n / 2) / n;
            psi_a = psi + (half_sel != 0 ? 180 * 256 : 0);
            cos_sin(-psi_a, cz0, sz0);
            cos_sin(-tilt, cy, sy);
            cos_sin(-rot_a, cz1, sz1);
            cyz0 = qmul(cy, cz0);
            res.valid = 1'b1;
            res.rot  = clamp(rot_a, 20);
            res.tilt = tilt;
            res.psi  = clamp(psi_a, 19);
            res.sx = project_row(qmul(cyz0, cz1) - qmul(sz0, sz1),
                                 -qmul(cz1, sz0) - qmul(cyz0, sz1),
                                 qmul(sy, cz0));
            res.sy = project_row(qmul(qmul(cy, cz1), sz0) + qmul(cz0, sz1),
                                 qmul(cz0, cz1) - qmul(qmul(cy, sz0), sz1),
                                 qmul(sy, sz0));
            return res;
        endfunction

        function void note_beat(longint k, longint rot, longint tilt, longint psi);
            pending.push_back(predict_copy(k, rot, tilt, psi));
            beats_in++;
        endfunction

        function void report(string name, longint exp_v, longint act_v);
            errors++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, name, exp_v, act_v);
        endfunction

        function void check_beat(copy_result_t got);
            copy_result_t want;
            beats_out++;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t ns: result beat with nothing expected, expected none, actual rot_out %0d",
                         $time, got.rot);
                return;
            end
            want = pending.pop_front();
            if (want.valid)
                valid_seen++;
            if (got.valid != want.valid) report("index_valid", want.valid, got.valid);
            if (got.rot != want.rot)     report("rot_out", want.rot, got.rot);
            if (got.tilt != want.tilt)   report("tilt_out", want.tilt, got.tilt);
            if (got.psi != want.psi)     report("psi_out", want.psi, got.psi);
            if (got.sx != want.sx)       report("shift_x", want.sx, got.sx);
            if (got.sy != want.sy)       report("shift_y", want.sy, got.sy);
        endfunction
    endclass

    logic                        clk;
    logic                        rst_n;
    logic                        start;
    logic                        busy;
    logic                        cfg_write;
    logic [CFG_IDX_W-1:0]        cfg_index;
    logic [CFG_W-1:0]            cfg_data;
    logic [K_W-1:0]              copy_index;
    logic signed [ANG_W-1:0]     rot_in;
    logic signed [ANG_W-1:0]     tilt_in;
    logic signed [ANG_W-1:0]     psi_in;
    logic                        done;
    logic                        index_valid;
    logic signed [ROT_W-1:0]     rot_out;
    logic signed [ANG_W-1:0]     tilt_out;
    logic signed [ANG_W-1:0]     psi_out;
    logic signed [SHIFT_W-1:0]   shift_x;
    logic signed [SHIFT_W-1:0]   shift_y;

    euler_scoreboard sb;
    // When set, the sender never idles between beats.
    bit back_to_back;

    symmetry_copy_euler_offset_top uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .copy_index(copy_index),
        .rot_in(rot_in),
        .tilt_in(tilt_in),
        .psi_in(psi_in),
        .done(done),
        .index_valid(index_valid),
        .rot_out(rot_out),
        .tilt_out(tilt_out),
        .psi_out(psi_out),
        .shift_x(shift_x),
        .shift_y(shift_y)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Inputs are driven at the rising edge, so the falling edge sees exactly the
    // values that the next rising edge will take. Both the input handshake and
    // the result strobe are observed there.
    always @(negedge clk)
    begin
        copy_result_t got;
        if (rst_n)
        begin
            if (start && !busy)
                sb.note_beat(longint'(copy_index), longint'(rot_in),
                             longint'(tilt_in), longint'(psi_in));
            if (done)
            begin
                got.valid = index_valid;
                got.rot   = longint'(rot_out);
                got.tilt  = longint'(tilt_out);
                got.psi   = longint'(psi_out);
                got.sx    = longint'(shift_x);
                got.sy    = longint'(shift_y);
                sb.check_beat(got);
            end
        end
    end

    // Drives one input beat after a random idle gap and returns on the rising
    // edge that accepts it. start stays high if the next beat follows at once.
    task automatic send_beat(input logic [K_W-1:0] k, input logic [ANG_W-1:0] rot,
                             input logic [ANG_W-1:0] tilt, input logic [ANG_W-1:0] psi);
        int gap;
        gap = back_to_back ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        copy_index <= k;
        rot_in     <= rot;
        tilt_in    <= tilt;
        psi_in     <= psi;
        @(negedge clk);
        while (busy) @(negedge clk);
        @(posedge clk);
    endtask

    // Lowers start, then waits until every expected beat has come back and the
    // pipeline has had time to empty. Registers are only written after this.
    task automatic drain_pipeline();
        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (PIPE_LAT + 2) @(posedge clk);
    endtask

    // Writes one register and mirrors it into the predictor.
    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_GROUP_KIND:     sb.dihedral  = val[0];
            REG_SYMMETRY_ORDER: sb.order_reg = longint'(val[K_W-1:0]);
            REG_OFFSET_X:       sb.ofs_x     = longint'($signed(val));
            REG_OFFSET_Y:       sb.ofs_y     = longint'($signed(val));
            REG_OFFSET_Z:       sb.ofs_z     = longint'($signed(val));
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_group(input logic kind, input logic [K_W-1:0] order,
                             input logic [CFG_W-1:0] ox, input logic [CFG_W-1:0] oy,
                             input logic [CFG_W-1:0] oz);
        // The upper data bits are don't-care for the narrow registers, so they
        // carry random values.
        write_reg(REG_GROUP_KIND, {18'($urandom_range(0, 262143)), kind});
        write_reg(REG_SYMMETRY_ORDER, {13'($urandom), order});
        write_reg(REG_OFFSET_X, ox);
        write_reg(REG_OFFSET_Y, oy);
        write_reg(REG_OFFSET_Z, oz);
    endtask

    // Angles are mostly anywhere in the field, with some kept inside one turn
    // and some on the wrap points of the reduction.
    function automatic logic [ANG_W-1:0] pick_angle();
        case ($urandom_range(0, 5))
            0: return ANG_W'($urandom_range(0, 2 * 92160) - 92160);
            1: return ANG_W'(($urandom_range(0, 8) - 4) * 23040);
            default: return ANG_W'($urandom);
        endcase
    endfunction

    initial
    begin
        int copies;
        logic [K_W-1:0] k;
        logic [K_W-1:0] ord;
        sb = new();
        back_to_back = 1'b0;
        rst_n      = 1'b0;
        start      = 1'b0;
        cfg_write  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        copy_index = '0;
        rot_in     = '0;
        tilt_in    = '0;
        psi_in     = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed beats in the reset setting: cyclic order one, zero offset.
        // Copy one and above are already out of range here.
        send_beat(6'd0, 19'sd0, 19'sd0, 19'sd0);
        send_beat(6'd1, 19'sd100, 19'sd200, 19'sd300);
        send_beat(6'd63, 19'h3FFFF, 19'h40000, 19'h3FFFF);
        drain_pipeline();

        // Dihedral order four with the largest offsets: both halves, the limits
        // of each angle field and the wrap points of the angle reduction.
        set_group(1'b1, 6'd4, 19'h3FFFF, 19'h40000, 19'h3FFFF);
        send_beat(6'd0, 19'h3FFFF, 19'h3FFFF, 19'h3FFFF);
        send_beat(6'd3, 19'h40000, 19'h40000, 19'h40000);
        send_beat(6'd4, 19'h3FFFF, 19'sd0, 19'h3FFFF);
        send_beat(6'd7, 19'sd184319, -19'sd184320, 19'sd184319);
        send_beat(6'd8, 19'sd5, 19'sd5, 19'sd5);
        send_beat(6'd5, 19'sd92160, 19'sd23040, -19'sd46080);
        send_beat(6'd6, -19'sd92160, 19'sd46080, 19'sd69120);
        send_beat(6'd1, 19'sd184320 - 1, 19'sd23040, 19'sd0);
        drain_pipeline();

        // Order zero gives no valid copy; an order above the maximum saturates.
        set_group(1'b0, 6'd0, 19'sd256, 19'sd256, 19'sd256);
        send_beat(6'd0, 19'sd1000, 19'sd1000, 19'sd1000);
        send_beat(6'd31, 19'sd1000, 19'sd1000, 19'sd1000);
        drain_pipeline();
        set_group(1'b1, 6'd63, 19'h40000, 19'h40000, 19'h40000);
        send_beat(6'd31, 19'sd7, 19'sd8, 19'sd9);
        send_beat(6'd32, 19'h3FFFF, 19'h3FFFF, 19'h3FFFF);
        send_beat(6'd63, 19'h40000, 19'h40000, 19'h40000);
        drain_pipeline();

        // Random phases. The first four pin the order to extremes, two also the
        // offsets; the rest draw everything. Each phase ends with a full drain,
        // which is also the pause in which the sender waits for every result.
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: ord = 6'd1;
                1: ord = 6'd32;
                2: ord = 6'd0;
                3: ord = 6'd63;
                default: ord = 6'($urandom_range(1, 32));
            endcase
            if (phase == 1)
                set_group(1'b1, ord, 19'h3FFFF, 19'h3FFFF, 19'h3FFFF);
            else if (phase == 2)
                set_group(1'b0, ord, 19'h40000, 19'h40000, 19'h40000);
            else
                set_group(1'($urandom), ord, 19'($urandom), 19'($urandom), 19'($urandom));
            copies = (sb.order_reg > MAX_ORDER) ? MAX_ORDER : int'(sb.order_reg);
            copies = sb.dihedral ? 2 * copies : copies;
            back_to_back = (phase % 3 == 2);
            for (int i = 0; i < 62; i++)
            begin
                // Most beats pick a legal copy; the rest roam the whole field.
                if (copies > 0 && $urandom_range(0, 9) < 8)
                    k = 6'($urandom_range(0, copies - 1));
                else
                    k = 6'($urandom);
                send_beat(k, pick_angle(), pick_angle(), pick_angle());
            end
            drain_pipeline();
        end

        repeat (PIPE_LAT + 5) @(posedge clk);
        $display("Covered %0d input beats and %0d result beats, %0d of them valid copies,",
                 sb.beats_in, sb.beats_out, sb.valid_seen);
        $display("across cyclic and dihedral groups with orders from zero to beyond the maximum.");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Simulation PASSED");
        else
        begin
            if (sb.pending.size() != 0)
                $display("%0t ns: %0d result beats never arrived, expected 0, actual %0d",
                         $time, sb.pending.size(), sb.pending.size());
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog: far longer than the slowest correct run.
    initial
    begin
        #3000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
